/* src/s2a_pkg.sv */
`default_nettype none

package s2a_pkg;

    localparam int BUFFER_SIZE_DEF = 256;

    localparam logic       CMD_SCAN   = 1'b0;
    localparam logic       CMD_READ   = 1'b1;

    localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] RSHIFT_BREAK = 8'hB6;

    typedef logic [6:0] t_char;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming beat
        logic exec;      // translate and push, or start a pop
        logic pop_load;  // present the character read from the store
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_read;
        logic empty;
    } t_dp_stat;

    // set-1 make code to ASCII, plain or shifted; zero means no character
    function automatic t_char key_lookup(input logic [6:0] code, input logic shift);
        t_char ch;
        ch = 7'h00;
        case (code)
            7'd1:  ch = 7'h1B;
            7'd2:  ch = shift ? 7'h21 : 7'h31;
            7'd3:  ch = shift ? 7'h40 : 7'h32;
            7'd4:  ch = shift ? 7'h23 : 7'h33;
            7'd5:  ch = shift ? 7'h24 : 7'h34;
            7'd6:  ch = shift ? 7'h25 : 7'h35;
            7'd7:  ch = shift ? 7'h5E : 7'h36;
            7'd8:  ch = shift ? 7'h26 : 7'h37;
            7'd9:  ch = shift ? 7'h2A : 7'h38;
            7'd10: ch = shift ? 7'h28 : 7'h39;
            7'd11: ch = shift ? 7'h29 : 7'h30;
            7'd12: ch = shift ? 7'h5F : 7'h2D;
            7'd13: ch = shift ? 7'h2B : 7'h3D;
            7'd14: ch = 7'h08;
            7'd15: ch = 7'h09;
            7'd16: ch = shift ? 7'h51 : 7'h71;
            7'd17: ch = shift ? 7'h57 : 7'h77;
            7'd18: ch = shift ? 7'h45 : 7'h65;
            7'd19: ch = shift ? 7'h52 : 7'h72;
            7'd20: ch = shift ? 7'h54 : 7'h74;
            7'd21: ch = shift ? 7'h59 : 7'h79;
            7'd22: ch = shift ? 7'h55 : 7'h75;
            7'd23: ch = shift ? 7'h49 : 7'h69;
            7'd24: ch = shift ? 7'h4F : 7'h6F;
            7'd25: ch = shift ? 7'h50 : 7'h70;
            7'd26: ch = shift ? 7'h7B : 7'h5B;
            7'd27: ch = shift ? 7'h7D : 7'h5D;
            7'd28: ch = 7'h0A;
            7'd30: ch = shift ? 7'h41 : 7'h61;
            7'd31: ch = shift ? 7'h53 : 7'h73;
            7'd32: ch = shift ? 7'h44 : 7'h64;
            7'd33: ch = shift ? 7'h46 : 7'h66;
            7'd34: ch = shift ? 7'h47 : 7'h67;
            7'd35: ch = shift ? 7'h48 : 7'h68;
            7'd36: ch = shift ? 7'h4A : 7'h6A;
            7'd37: ch = shift ? 7'h4B : 7'h6B;
            7'd38: ch = shift ? 7'h4C : 7'h6C;
            7'd39: ch = shift ? 7'h3A : 7'h3B;
            7'd40: ch = shift ? 7'h22 : 7'h27;
            7'd41: ch = shift ? 7'h7E : 7'h60;
            7'd43: ch = shift ? 7'h7C : 7'h5C;
            7'd44: ch = shift ? 7'h5A : 7'h7A;
            7'd45: ch = shift ? 7'h58 : 7'h78;
            7'd46: ch = shift ? 7'h43 : 7'h63;
            7'd47: ch = shift ? 7'h56 : 7'h76;
            7'd48: ch = shift ? 7'h42 : 7'h62;
            7'd49: ch = shift ? 7'h4E : 7'h6E;
            7'd50: ch = shift ? 7'h4D : 7'h6D;
            7'd51: ch = shift ? 7'h3C : 7'h2C;
            7'd52: ch = shift ? 7'h3E : 7'h2E;
            7'd53: ch = shift ? 7'h3F : 7'h2F;
            7'd55: ch = 7'h2A;
            7'd57: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* src/scancode_to_ascii_fifo.sv */
`default_nettype none

// Set-1 scan code to ASCII translator with a character FIFO.
// Input channel: drive i_command and i_scan_code with start high; the beat
// is taken at a rising edge where start is high and busy is low. A scan
// beat (command 0) updates the shift flag or translates a make code and
// pushes the character; a read beat (command 1) pops one character.
// Result channel: every beat gives exactly one result, shown on o_char_valid,
// o_char_out, o_not_empty and o_dropped for one cycle while o_strobe is high.
// The receiver cannot stall; a result not taken in its strobe cycle is lost.
// Sequence: the accepting edge captures the beat, the execute state registers
// the result and raises o_strobe; a read that pops instead loads the store
// output into r_rdata in the execute state and shows it from the pop state.
// A new beat is not accepted until the controller is back in idle; busy
// stays high while the controller works through the beat.
// Reset (i_rst_n low, synchronous): empty FIFO, shift released, no strobe.
// The store itself is not cleared; only written entries are ever read.
// The FIFO holds BUFFER_SIZE-1 characters; a character that meets a full
// FIFO is discarded and flagged on o_dropped.
module scancode_to_ascii_fifo #(
    parameter int BUFFER_SIZE = s2a_pkg::BUFFER_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_scan_code,
    output logic             o_strobe,
    output logic             o_char_valid,
    output logic [6:0]       o_char_out,
    output logic             o_not_empty,
    output logic             o_dropped
);
    import s2a_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequence each beat: capture, execute, optionally present the pop
    s2a_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // translation table, shift flag, ring pointers, store and result registers
    s2a_dpath #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_command),
        .i_scan_code  (i_scan_code),
        .o_strobe     (o_strobe),
        .o_char_valid (o_char_valid),
        .o_char_out   (o_char_out),
        .o_not_empty  (o_not_empty),
        .o_dropped    (o_dropped)
    );

endmodule

`default_nettype wire

/* src/s2a_ctrl.sv */
`default_nettype none

module s2a_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire s2a_pkg::t_dp_stat  i_stat,
    output s2a_pkg::t_dp_cmd        o_cmd
);
    import s2a_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign busy = (r_state != ST_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.pop_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                // a pop goes through ST_POP so the registered store read is ready for pop_load
                if (i_stat.is_read && !i_stat.empty) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* src/s2a_dpath.sv */
`default_nettype none

module s2a_dpath #(
    parameter int BUFFER_SIZE = s2a_pkg::BUFFER_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire s2a_pkg::t_dp_cmd   i_cmd,
    output s2a_pkg::t_dp_stat       o_stat,
    input  wire logic               i_command,
    input  wire logic [7:0]         i_scan_code,
    output logic                    o_strobe,
    output logic                    o_char_valid,
    output logic [6:0]              o_char_out,
    output logic                    o_not_empty,
    output logic                    o_dropped
);
    import s2a_pkg::*;

    localparam int PW = $clog2(BUFFER_SIZE);
    localparam logic [PW-1:0] LAST = PW'(BUFFER_SIZE - 1);

    t_char          r_store [BUFFER_SIZE];
    t_char          r_rdata;
    logic           r_cmd;
    logic [7:0]     r_code;
    logic           r_shift;
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW-1:0]  n_wr;
    logic [PW-1:0]  n_rd;
    logic           r_strobe;
    logic           r_char_valid;
    t_char          r_char_out;
    logic           r_not_empty;
    logic           r_dropped;

    t_char          key_char;
    logic           is_key;
    logic           empty;
    logic           full;
    logic           push;
    logic           drop;
    logic           pop;

    assign n_wr  = (r_wr == LAST) ? '0 : r_wr + 1'b1;
    assign n_rd  = (r_rd == LAST) ? '0 : r_rd + 1'b1;
    assign empty = (r_wr == r_rd);
    assign full  = (n_wr == r_rd);

    // shift codes map to zero entries, so they never reach the store
    assign key_char = key_lookup(r_code[6:0], r_shift);
    assign is_key   = !r_code[7] && (key_char != 7'h00);

    assign push = i_cmd.exec && (r_cmd == CMD_SCAN) && is_key && !full;
    assign drop = i_cmd.exec && (r_cmd == CMD_SCAN) && is_key && full;
    assign pop  = i_cmd.exec && (r_cmd == CMD_READ) && !empty;

    assign o_stat.is_read = (r_cmd == CMD_READ);
    assign o_stat.empty   = empty;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_command;
            r_code <= i_scan_code;
        end
    end

    // character store
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_store[r_wr] <= key_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rdata <= r_store[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_shift <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= n_wr;
            end
            if (pop) begin
                r_rd <= n_rd;
            end
            if (i_cmd.exec && (r_cmd == CMD_SCAN)) begin
                if ((r_code == LSHIFT_MAKE) || (r_code == RSHIFT_MAKE)) begin
                    r_shift <= 1'b1;
                end else if ((r_code == LSHIFT_BREAK) || (r_code == RSHIFT_BREAK)) begin
                    r_shift <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.exec && !pop) || i_cmd.pop_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !pop) begin
            r_char_valid <= 1'b0;
            r_char_out   <= 7'h00;
            r_not_empty  <= push || !empty;
            r_dropped    <= drop;
        end else if (i_cmd.pop_load) begin
            r_char_valid <= 1'b1;
            r_char_out   <= r_rdata;
            r_not_empty  <= !empty;
            r_dropped    <= 1'b0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_char_valid = r_char_valid;
    assign o_char_out   = r_char_out;
    assign o_not_empty  = r_not_empty;
    assign o_dropped    = r_dropped;

endmodule

`default_nettype wire
